/* design/assert_macros.svh */
// Concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER_CLK(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER_CLK(label, clk, rst_n, cond)
`endif

`endif

/* design/mtep_pkg.sv */
package mtep_pkg;

  localparam int unsigned TIME_WIDTH = 48;
  localparam int unsigned VLQ_WIDTH  = 28;
  localparam int unsigned LEN_WIDTH  = 32;

  localparam logic [7:0] TAG_M = 8'h4D;
  localparam logic [7:0] TAG_T = 8'h54;
  localparam logic [7:0] TAG_R = 8'h72;
  localparam logic [7:0] TAG_K = 8'h6B;

  localparam logic [7:0] STATUS_META    = 8'hFF;
  localparam logic [7:0] STATUS_SYS_LOW = 8'hF0;
  localparam logic [7:0] META_END_TRACK = 8'h2F;

  localparam logic [3:0] TYPE_PROGRAM  = 4'hC;
  localparam logic [3:0] TYPE_PRESSURE = 4'hD;

  typedef enum logic [3:0] {
    PH_TAG    = 4'd0,
    PH_LEN    = 4'd1,
    PH_DELTA  = 4'd2,
    PH_STATUS = 4'd3,
    PH_ARGS   = 4'd4,
    PH_MTYPE  = 4'd5,
    PH_MLEN   = 4'd6,
    PH_SKIP   = 4'd7
  } phase_e;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_TAG    = 2'd1,
    ERR_STATUS = 2'd2,
    ERR_LENGTH = 2'd3
  } err_e;

  typedef enum logic {
    CAT_CHANNEL = 1'b0,
    CAT_META    = 1'b1
  } cat_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } byte_stage_t;

  typedef struct packed {
    cat_e                  category;
    logic [7:0]            kind;
    logic [3:0]            channel;
    logic [7:0]            arg_first;
    logic [7:0]            arg_second;
    logic [VLQ_WIDTH-1:0]  delta_ticks;
    logic [TIME_WIDTH-1:0] absolute_ticks;
    logic [LEN_WIDTH-1:0]  chunk_length;
    logic                  track_end;
    err_e                  error_code;
  } evt_t;

  function automatic logic [7:0] tag_letter(input logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0: r = TAG_M;
      2'd1: r = TAG_T;
      2'd2: r = TAG_R;
      default: r = TAG_K;
    endcase
    return r;
  endfunction

  // program change and channel pressure take one data byte
  function automatic logic [1:0] arg_count(input logic [3:0] ev_type);
    return (ev_type == TYPE_PROGRAM || ev_type == TYPE_PRESSURE) ? 2'd1 : 2'd2;
  endfunction

endpackage

/* design/mtep_if.sv */
interface mtep_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface mtep_event_if import mtep_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic                  category;
  logic [7:0]            kind;
  logic [3:0]            channel;
  logic [7:0]            arg_first;
  logic [7:0]            arg_second;
  logic [VLQ_WIDTH-1:0]  delta_ticks;
  logic [TIME_WIDTH-1:0] absolute_ticks;
  logic [LEN_WIDTH-1:0]  chunk_length;
  logic                  track_end;
  logic [1:0]            error_code;

  modport source (
    output valid, input ready,
    output category, output kind, output channel, output arg_first, output arg_second,
    output delta_ticks, output absolute_ticks, output chunk_length, output track_end,
    output error_code
  );
  modport sink (
    input valid, output ready,
    input category, input kind, input channel, input arg_first, input arg_second,
    input delta_ticks, input absolute_ticks, input chunk_length, input track_end,
    input error_code
  );
endinterface

/* design/mtep_in_stage.sv */
module mtep_in_stage import mtep_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [7:0]  data_i,
  output logic        ready_o,
  input  logic        consume_i,
  output byte_stage_t stage_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q, data_d;
  logic       load;

  assign ready_o = !valid_q || consume_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (load) begin
      valid_d = 1'b1;
      data_d  = data_i;
    end else if (consume_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign stage_o.valid = valid_q;
  assign stage_o.data  = data_q;

endmodule

/* design/mtep_core.sv */
module mtep_core import mtep_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  byte_stage_t stage_i,
  input  logic        can_take_i,
  output logic        fire_o,
  output logic        res_valid_o,
  output evt_t        res_o
);

  phase_e                phase_q, phase_d;
  logic [2:0]            idx_q, idx_d;
  logic [LEN_WIDTH-1:0]  len_q, len_d;
  logic [VLQ_WIDTH-1:0]  vlq_q, vlq_d;
  logic [VLQ_WIDTH-1:0]  delta_q, delta_d;
  logic [TIME_WIDTH-1:0] time_q, time_d;
  logic [7:0]            status_q, status_d;
  logic [15:0]           args_q, args_d;
  logic [VLQ_WIDTH-1:0]  skip_q, skip_d;

  logic [7:0]            b;
  logic [2:0]            idx_inc;
  logic [VLQ_WIDTH-1:0]  vlq_next;
  logic [VLQ_WIDTH-1:0]  skip_dec;
  logic [3:0]            ev_type;
  logic [1:0]            need;
  logic [15:0]           args_new;
  logic                  meta_end;
  evt_t                  meta_res;
  evt_t                  chan_res;

  assign fire_o   = stage_i.valid && can_take_i;
  assign b        = stage_i.data;
  assign idx_inc  = idx_q + 3'd1;
  assign vlq_next = {vlq_q[VLQ_WIDTH-8:0], b[6:0]};
  assign skip_dec = skip_q - VLQ_WIDTH'(1);
  assign ev_type  = status_q[7:4];
  assign need     = arg_count(ev_type);
  assign args_new = (idx_q == 3'd0) ? {8'h00, b} : {b, args_q[7:0]};
  assign meta_end = (args_q[7:0] == META_END_TRACK);

  always_comb begin
    meta_res                = '0;
    meta_res.category       = CAT_META;
    meta_res.kind           = args_q[7:0];
    meta_res.delta_ticks    = delta_q;
    meta_res.absolute_ticks = time_q;
    meta_res.chunk_length   = len_q;
    meta_res.track_end      = meta_end;
    meta_res.error_code     = ERR_NONE;

    chan_res                = '0;
    chan_res.category       = CAT_CHANNEL;
    chan_res.kind           = {4'h0, ev_type};
    chan_res.channel        = status_q[3:0];
    chan_res.arg_first      = args_new[7:0];
    chan_res.arg_second     = (need == 2'd2) ? args_new[15:8] : 8'h00;
    chan_res.delta_ticks    = delta_q;
    chan_res.absolute_ticks = time_q;
    chan_res.chunk_length   = len_q;
    chan_res.error_code     = ERR_NONE;
  end

  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    len_d       = len_q;
    vlq_d       = vlq_q;
    delta_d     = delta_q;
    time_d      = time_q;
    status_d    = status_q;
    args_d      = args_q;
    skip_d      = skip_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (fire_o) begin
      unique case (phase_q)
        PH_TAG: begin
          if (b == tag_letter(idx_q[1:0])) begin
            idx_d = idx_inc;
            if (idx_inc[2]) begin
              idx_d   = 3'd0;
              len_d   = '0;
              phase_d = PH_LEN;
            end
          end else begin
            res_valid_o      = 1'b1;
            res_o.error_code = ERR_TAG;
            idx_d            = (b == TAG_M) ? 3'd1 : 3'd0;
          end
        end
        PH_LEN: begin
          len_d = {len_q[LEN_WIDTH-9:0], b};
          idx_d = idx_inc;
          if (idx_inc[2]) begin
            idx_d   = 3'd0;
            vlq_d   = '0;
            time_d  = '0;
            phase_d = PH_DELTA;
          end
        end
        PH_DELTA: begin
          vlq_d = vlq_next;
          idx_d = idx_inc;
          if (!b[7]) begin
            delta_d = vlq_next;
            time_d  = time_q + TIME_WIDTH'(vlq_next);
            idx_d   = 3'd0;
            phase_d = PH_STATUS;
          end else if (idx_inc[2]) begin
            res_valid_o      = 1'b1;
            res_o.error_code = ERR_LENGTH;
            idx_d            = 3'd0;
            phase_d          = PH_TAG;
          end
        end
        PH_STATUS: begin
          if (b == STATUS_META) begin
            status_d = b;
            phase_d  = PH_MTYPE;
          end else if (!b[7] || b >= STATUS_SYS_LOW) begin
            res_valid_o      = 1'b1;
            res_o.error_code = ERR_STATUS;
            idx_d            = 3'd0;
            phase_d          = PH_TAG;
          end else begin
            status_d = b;
            args_d   = '0;
            idx_d    = 3'd0;
            phase_d  = PH_ARGS;
          end
        end
        PH_ARGS: begin
          args_d = args_new;
          idx_d  = idx_inc;
          if (idx_inc >= {1'b0, need}) begin
            res_valid_o = 1'b1;
            res_o       = chan_res;
            idx_d       = 3'd0;
            vlq_d       = '0;
            phase_d     = PH_DELTA;
          end
        end
        PH_MTYPE: begin
          args_d  = {8'h00, b};
          idx_d   = 3'd0;
          vlq_d   = '0;
          phase_d = PH_MLEN;
        end
        PH_MLEN: begin
          vlq_d = vlq_next;
          idx_d = idx_inc;
          if (!b[7]) begin
            skip_d = vlq_next;
            idx_d  = 3'd0;
            if (vlq_next == '0) begin
              res_valid_o = 1'b1;
              res_o       = meta_res;
              vlq_d       = '0;
              phase_d     = meta_end ? PH_TAG : PH_DELTA;
            end else begin
              phase_d = PH_SKIP;
            end
          end else if (idx_inc[2]) begin
            res_valid_o      = 1'b1;
            res_o.error_code = ERR_LENGTH;
            idx_d            = 3'd0;
            phase_d          = PH_TAG;
          end
        end
        PH_SKIP: begin
          skip_d = skip_dec;
          if (skip_dec == '0) begin
            res_valid_o = 1'b1;
            res_o       = meta_res;
            idx_d       = 3'd0;
            vlq_d       = '0;
            phase_d     = meta_end ? PH_TAG : PH_DELTA;
          end
        end
        default: begin
          phase_d = PH_TAG;
          idx_d   = 3'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_TAG;
      idx_q    <= 3'd0;
      len_q    <= '0;
      vlq_q    <= '0;
      delta_q  <= '0;
      time_q   <= '0;
      status_q <= 8'h00;
      args_q   <= 16'h0000;
      skip_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      idx_q    <= idx_d;
      len_q    <= len_d;
      vlq_q    <= vlq_d;
      delta_q  <= delta_d;
      time_q   <= time_d;
      status_q <= status_d;
      args_q   <= args_d;
      skip_q   <= skip_d;
    end
  end

endmodule

/* design/mtep_out_stage.sv */
module mtep_out_stage import mtep_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic fire_i,
  input  logic res_valid_i,
  input  evt_t res_i,
  output logic can_take_o,
  input  logic ready_i,
  output logic valid_o,
  output evt_t evt_o
);

  logic valid_q, valid_d;
  evt_t evt_q, evt_d;

  assign can_take_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    evt_d   = evt_q;
    if (can_take_o) begin
      valid_d = fire_i && res_valid_i;
      evt_d   = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    evt_q <= evt_d;
  end

  assign valid_o = valid_q;
  assign evt_o   = evt_q;

endmodule

/* design/midi_track_event_parser.sv */
// Data path: each byte is held in the input register, then its result in the result register.
// Throughput: one byte per cycle; back-pressure on the result side stalls the input
// register, which still takes one byte while the result register is held.
// Reset (rst_ni low, asynchronous): parser returns to MTrk tag search, all counters,
// length and running time cleared, both pipeline registers empty.
`include "assert_macros.svh"

module midi_track_event_parser import mtep_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  mtep_byte_if.sink    byte_i,
  mtep_event_if.source event_o
);

  byte_stage_t stage;
  logic        can_take;
  logic        fire;
  logic        res_valid;
  evt_t        res;
  evt_t        evt;

  mtep_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (byte_i.valid),
    .data_i    (byte_i.data_byte),
    .ready_o   (byte_i.ready),
    .consume_i (fire),
    .stage_o   (stage)
  );

  mtep_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_i     (stage),
    .can_take_i  (can_take),
    .fire_o      (fire),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  mtep_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .res_valid_i (res_valid),
    .res_i       (res),
    .can_take_o  (can_take),
    .ready_i     (event_o.ready),
    .valid_o     (event_o.valid),
    .evt_o       (evt)
  );

  assign event_o.category       = evt.category;
  assign event_o.kind           = evt.kind;
  assign event_o.channel        = evt.channel;
  assign event_o.arg_first      = evt.arg_first;
  assign event_o.arg_second     = evt.arg_second;
  assign event_o.delta_ticks    = evt.delta_ticks;
  assign event_o.absolute_ticks = evt.absolute_ticks;
  assign event_o.chunk_length   = evt.chunk_length;
  assign event_o.track_end      = evt.track_end;
  assign event_o.error_code     = evt.error_code;

  // a held result must block the parser
  `ASSERT_NEVER_CLK(a_no_fire_on_stall, clk_i, rst_ni, event_o.valid && !event_o.ready && fire)
  // error items carry nothing but the code
  `ASSERT_CLK(a_error_clean, clk_i, rst_ni, (event_o.valid && event_o.error_code != ERR_NONE) |-> (event_o.category == CAT_CHANNEL && event_o.track_end == 1'b0 && event_o.delta_ticks == '0))
  // end of track is only flagged on the meta subtype
  `ASSERT_CLK(a_end_is_meta, clk_i, rst_ni, (event_o.valid && event_o.track_end) |-> (event_o.category == CAT_META && event_o.kind == META_END_TRACK))

endmodule

/* dv/midi_track_event_parser_test.sv */
`timescale 1ns / 1ps

module midi_track_event_parser_test;
  import mtep_pkg::*;

  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mtep_byte_if  bif ();
  mtep_event_if eif ();

  midi_track_event_parser dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (bif),
    .event_o (eif)
  );

  logic [7:0] tag_seq [4] = '{TAG_M, TAG_T, TAG_R, TAG_K};

  // bad tag with restart on M, max length, program change with top-bit arg,
  // max delta, two-arg note event, empty end-of-track meta
  logic [7:0] opening_seq [24] = '{
    TAG_M, TAG_T, TAG_M, TAG_T, TAG_R, TAG_K,
    8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'h00, 8'hC5, 8'h80,
    8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h9F, 8'hFF, 8'h00,
    8'h00, STATUS_META, META_END_TRACK, 8'h00
  };

  logic [7:0] track_bytes [$];
  evt_t       pending_events [$];

  int gap_pct;
  int stall_pct;
  int burst_req;
  int burst_seen;
  int hold_left;
  int idle_cycles;
  logic offer_taken;

  int n_bytes;
  int n_chan;
  int n_meta;
  int n_end;
  int n_err;
  int n_fail;

  // parser state mirror
  phase_e                prs_phase;
  logic [2:0]            prs_idx;
  logic [LEN_WIDTH-1:0]  prs_len;
  logic [VLQ_WIDTH-1:0]  prs_acc;
  logic [VLQ_WIDTH-1:0]  prs_delta;
  logic [VLQ_WIDTH-1:0]  prs_skip;
  logic [TIME_WIDTH-1:0] prs_time;
  logic [7:0]            prs_status;
  logic [15:0]           prs_args;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic evt_t error_event(input err_e code);
    evt_t ev;
    ev = '0;
    ev.error_code = code;
    prs_phase = PH_TAG;
    prs_idx = '0;
    return ev;
  endfunction

  function automatic evt_t finish_event();
    evt_t ev;
    ev = '0;
    ev.delta_ticks = prs_delta;
    ev.absolute_ticks = prs_time;
    ev.chunk_length = prs_len;
    ev.error_code = ERR_NONE;
    prs_idx = '0;
    prs_acc = '0;
    prs_phase = PH_DELTA;
    return ev;
  endfunction

  function automatic evt_t meta_event();
    evt_t ev;
    ev = finish_event();
    ev.category = CAT_META;
    ev.kind = prs_args[7:0];
    ev.track_end = (prs_args[7:0] == META_END_TRACK);
    if (ev.track_end) prs_phase = PH_TAG;
    return ev;
  endfunction

  function automatic void vlq_step(input logic [7:0] b, output bit done, output bit overlong);
    prs_acc = {prs_acc[VLQ_WIDTH-8:0], b[6:0]};
    prs_idx = prs_idx + 3'd1;
    done = !b[7];
    overlong = b[7] && (prs_idx >= 3'd4);
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, output evt_t ev);
    bit got;
    bit done;
    bit overlong;
    logic [3:0] ev_type;
    logic [2:0] need;
    got = 1'b0;
    ev = '0;
    case (prs_phase)
      PH_TAG: begin
        if (b == tag_seq[prs_idx[1:0]]) begin
          prs_idx = prs_idx + 3'd1;
          if (prs_idx >= 3'd4) begin
            prs_idx = '0;
            prs_len = '0;
            prs_phase = PH_LEN;
          end
        end else begin
          ev = error_event(ERR_TAG);
          prs_idx = (b == TAG_M) ? 3'd1 : 3'd0;
          got = 1'b1;
        end
      end
      PH_LEN: begin
        prs_len = {prs_len[LEN_WIDTH-9:0], b};
        prs_idx = prs_idx + 3'd1;
        if (prs_idx >= 3'd4) begin
          prs_idx = '0;
          prs_acc = '0;
          prs_time = '0;
          prs_phase = PH_DELTA;
        end
      end
      PH_DELTA: begin
        vlq_step(b, done, overlong);
        if (overlong) begin
          ev = error_event(ERR_LENGTH);
          got = 1'b1;
        end else if (done) begin
          prs_delta = prs_acc;
          prs_time = prs_time + TIME_WIDTH'(prs_acc);
          prs_idx = '0;
          prs_phase = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (b == STATUS_META) begin
          prs_status = b;
          prs_phase = PH_MTYPE;
        end else if (!b[7] || b >= STATUS_SYS_LOW) begin
          ev = error_event(ERR_STATUS);
          got = 1'b1;
        end else begin
          prs_status = b;
          prs_args = '0;
          prs_idx = '0;
          prs_phase = PH_ARGS;
        end
      end
      PH_ARGS: begin
        ev_type = prs_status[7:4];
        need = (ev_type == TYPE_PROGRAM || ev_type == TYPE_PRESSURE) ? 3'd1 : 3'd2;
        if (prs_idx == 3'd0) prs_args = {8'h00, b};
        else prs_args = {b, prs_args[7:0]};
        prs_idx = prs_idx + 3'd1;
        if (prs_idx >= need) begin
          ev = finish_event();
          ev.category = CAT_CHANNEL;
          ev.kind = {4'h0, ev_type};
          ev.channel = prs_status[3:0];
          ev.arg_first = prs_args[7:0];
          ev.arg_second = (need == 3'd2) ? prs_args[15:8] : 8'h00;
          got = 1'b1;
        end
      end
      PH_MTYPE: begin
        prs_args = {8'h00, b};
        prs_idx = '0;
        prs_acc = '0;
        prs_phase = PH_MLEN;
      end
      PH_MLEN: begin
        vlq_step(b, done, overlong);
        if (overlong) begin
          ev = error_event(ERR_LENGTH);
          got = 1'b1;
        end else if (done) begin
          prs_skip = prs_acc;
          prs_idx = '0;
          if (prs_skip == '0) begin
            ev = meta_event();
            got = 1'b1;
          end else begin
            prs_phase = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        prs_skip = prs_skip - VLQ_WIDTH'(1);
        if (prs_skip == '0) begin
          ev = meta_event();
          got = 1'b1;
        end
      end
      default: begin
        prs_phase = PH_TAG;
        prs_idx = '0;
      end
    endcase
    return got;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      n_fail++;
    end
  endtask

  always @(posedge clk_i) begin : take_bytes
    evt_t ev;
    if (!rst_ni) begin
      prs_phase = PH_TAG;
      prs_idx = '0;
      prs_len = '0;
      prs_acc = '0;
      prs_delta = '0;
      prs_skip = '0;
      prs_time = '0;
      prs_status = '0;
      prs_args = '0;
      offer_taken <= 1'b0;
    end else begin
      offer_taken <= bif.valid && bif.ready;
      if (bif.valid && bif.ready) begin
        if (decode_byte(bif.data_byte, ev)) pending_events = {pending_events, ev};
        void'(track_bytes.pop_front());
        n_bytes++;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      bif.valid <= 1'b0;
      bif.data_byte <= '0;
    end else if (!bif.valid || offer_taken) begin
      if (track_bytes.size() != 0 && $urandom_range(99) >= gap_pct) begin
        bif.valid <= 1'b1;
        bif.data_byte <= track_bytes[0];
      end else begin
        bif.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      eif.ready <= 1'b0;
      hold_left <= 0;
      burst_seen <= 0;
    end else if (burst_req != burst_seen) begin
      burst_seen <= burst_req;
      hold_left <= HOLD_CYCLES;
      eif.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      eif.ready <= 1'b0;
    end else begin
      eif.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin : watch_events
    evt_t want;
    if (rst_ni && eif.valid && eif.ready) begin
      if (pending_events.size() == 0) begin
        $error("event result with none expected");
        n_fail++;
      end else begin
        want = pending_events.pop_front();
        check_field("category", 64'(want.category), 64'(eif.category));
        check_field("kind", 64'(want.kind), 64'(eif.kind));
        check_field("channel", 64'(want.channel), 64'(eif.channel));
        check_field("arg_first", 64'(want.arg_first), 64'(eif.arg_first));
        check_field("arg_second", 64'(want.arg_second), 64'(eif.arg_second));
        check_field("delta_ticks", 64'(want.delta_ticks), 64'(eif.delta_ticks));
        check_field("absolute_ticks", 64'(want.absolute_ticks), 64'(eif.absolute_ticks));
        check_field("chunk_length", 64'(want.chunk_length), 64'(eif.chunk_length));
        check_field("track_end", 64'(want.track_end), 64'(eif.track_end));
        check_field("error_code", 64'(want.error_code), 64'(eif.error_code));
        if (want.error_code != ERR_NONE) n_err++;
        else if (want.category == CAT_META) n_meta++;
        else n_chan++;
        if (want.track_end) n_end++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (bif.valid && bif.ready) || (eif.valid && eif.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("midi_track_event_parser_test: FAIL");
      $finish;
    end
  end

  task automatic put(input logic [7:0] b);
    track_bytes = {track_bytes, b};
  endtask

  task automatic put_vlq(input logic [VLQ_WIDTH-1:0] v, input int pad);
    int n;
    n = 1;
    while (n < 4 && (v >> (7 * n)) != 0) n++;
    n = (n + pad > 4) ? 4 : n + pad;
    for (int i = n - 1; i >= 0; i--) put({i != 0, 7'(v >> (7 * i))});
  endtask

  function automatic logic [VLQ_WIDTH-1:0] pick_ticks();
    case ($urandom_range(7))
      0: return '0;
      1: return 28'h7F;
      2: return 28'h80;
      3: return '1;
      4: return 28'($urandom_range(16383));
      5: return 28'($urandom);
      default: return 28'($urandom_range(100));
    endcase
  endfunction

  task automatic put_noise();
    if ($urandom_range(2) == 0) begin
      put(TAG_M);
      put(TAG_T);
      put(8'($urandom));
    end else begin
      repeat ($urandom_range(3, 1)) put(8'($urandom));
    end
  endtask

  // mostly well-formed tracks; a few end early on a broken event
  task automatic put_track(input int events);
    logic [31:0] len;
    logic [7:0] sub;
    logic [3:0] ev_type;
    int roll;
    int plen;
    foreach (tag_seq[i]) put(tag_seq[i]);
    case ($urandom_range(3))
      0: len = '0;
      1: len = '1;
      default: len = $urandom;
    endcase
    for (int s = 3; s >= 0; s--) put(len[8*s +: 8]);
    repeat (events) begin
      roll = $urandom_range(99);
      if (roll < 4) begin
        repeat (4) put(8'h80 | 8'($urandom));
        return;
      end
      put_vlq(pick_ticks(), ($urandom_range(5) == 0) ? 2 : 0);
      if (roll < 8) begin
        put(8'($urandom_range(127)));
        return;
      end
      if (roll < 12) begin
        put(8'($urandom_range(254, 240)));
        return;
      end
      if (roll < 40) begin
        sub = 8'($urandom);
        put(STATUS_META);
        put(sub);
        if (roll < 15) begin
          repeat (4) put(8'h80 | 8'($urandom));
          return;
        end
        plen = ($urandom_range(30) == 0) ? $urandom_range(130, 120) : $urandom_range(4);
        put_vlq(VLQ_WIDTH'(plen), ($urandom_range(3) == 0) ? 1 : 0);
        repeat (plen) put(8'($urandom));
        if (sub == META_END_TRACK) return;
      end else begin
        ev_type = 4'($urandom_range(14, 8));
        put({ev_type, 4'($urandom)});
        put(8'($urandom));
        if (ev_type != TYPE_PROGRAM && ev_type != TYPE_PRESSURE) put(8'($urandom));
      end
    end
    put_vlq(pick_ticks(), 0);
    put(STATUS_META);
    put(META_END_TRACK);
    if ($urandom_range(4) == 0) begin
      put(8'h01);
      put(8'($urandom));
    end else begin
      put(8'h00);
    end
  endtask

  task automatic drain();
    while (track_bytes.size() != 0 || pending_events.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(input int gap, input int stall, input int budget, input bit squeeze);
    gap_pct = gap;
    stall_pct = stall;
    while (track_bytes.size() < budget) begin
      if ($urandom_range(3) == 0) put_noise();
      put_track($urandom_range(8, 2));
    end
    if (squeeze) burst_req++;
    drain();
  endtask

  initial begin
    gap_pct = 0;
    stall_pct = 0;
    burst_req = 0;
    n_bytes = 0;
    n_chan = 0;
    n_meta = 0;
    n_end = 0;
    n_err = 0;
    n_fail = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (opening_seq[i]) put(opening_seq[i]);
    drain();
    run_phase(0, 0, 90, 1'b0);
    run_phase(78, 0, 90, 1'b0);
    run_phase(0, 78, 90, 1'b0);
    run_phase(31, 31, 90, 1'b0);
    run_phase(0, 0, 80, 1'b1);
    repeat (8) @(posedge clk_i);
    $display("Fed %0d track bytes through five idle/stall mixes incl. a long output hold.",
             n_bytes);
    $display("Checked %0d channel, %0d meta (%0d track ends) and %0d error results.",
             n_chan, n_meta, n_end, n_err);
    if (n_fail == 0) begin
      $display("midi_track_event_parser_test: PASS");
    end else begin
      $display("midi_track_event_parser_test: FAIL");
    end
    $finish;
  end

endmodule
